// ----- hw/rtl/utf8v_pkg.sv -----
`timescale 1ns / 1ps

package utf8v_pkg;

   // Width of the code point counter; the result port shows its low 16 bits.
   localparam int CountWidth = 16;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_LEAD      = 3'd1,
      ERR_CONT      = 3'd2,
      ERR_TRUNC     = 3'd3,
      ERR_OVERLONG  = 3'd4,
      ERR_SURROGATE = 3'd5,
      ERR_NONCHAR   = 3'd6,
      ERR_RANGE     = 3'd7
   } error_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } item_type;

   typedef struct packed {
      logic        valid_res;
      error_type   error_kind;
      logic [15:0] code_point_count;
      logic        count_saturated;
   } result_type;

   // Value checks on a completed multi-byte sequence: lead, second and final byte.
   function automatic error_type strict_check(input logic [7:0] b0,
                                              input logic [7:0] b1,
                                              input logic [7:0] bl);
      error_type e;
      e = ERR_NONE;
      if (b0[7:5] == 3'b110) begin
         if (b0[7:1] == 7'b1100000) e = ERR_OVERLONG;
      end else if (b0[7:4] == 4'b1110) begin
         if (b0 == 8'he0 && b1[7:5] == 3'b100) e = ERR_OVERLONG;
         else if (b0 == 8'hed && b1[7:5] == 3'b101) e = ERR_SURROGATE;
         else if (b0 == 8'hef && b1 == 8'hbf && bl[7:1] == 7'b1011111) e = ERR_NONCHAR;
      end else begin
         if (b0 == 8'hf0 && b1[7:4] == 4'b1000) e = ERR_OVERLONG;
         else if ((b0 == 8'hf4 && b1 > 8'h8f) || b0 > 8'hf4) e = ERR_RANGE;
      end
      return e;
   endfunction

endpackage

// ----- hw/rtl/utf8v_core.sv -----
`timescale 1ns / 1ps

// Per-byte decode state and its update on each advance.
module utf8v_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  strict_mode,
   input  logic                  advance,
   input  utf8v_pkg::item_type   item,
   output utf8v_pkg::result_type result
);

   logic [7:0]                      lead_ff, lead_in;
   logic [7:0]                      second_ff, second_in;
   logic [1:0]                      pending_ff, pending_in;
   utf8v_pkg::error_type            error_ff, error_in;
   logic [utf8v_pkg::CountWidth-1:0] count_ff, count_in;
   logic                            sat_ff, sat_in;

   always_comb begin
      logic [7:0]           b;
      logic                 accept;
      utf8v_pkg::error_type e;
      b          = item.data_byte;
      accept     = 1'b0;
      e          = utf8v_pkg::ERR_NONE;
      lead_in    = lead_ff;
      second_in  = second_ff;
      pending_in = pending_ff;
      error_in   = error_ff;
      count_in   = count_ff;
      sat_in     = sat_ff;

      if (item.has_byte && error_ff == utf8v_pkg::ERR_NONE) begin
         if (pending_ff == 2'd0) begin
            if (!b[7]) begin
               accept = 1'b1;
            end else if (b[7:5] == 3'b110) begin
               lead_in = b; pending_in = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
               lead_in = b; pending_in = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
               lead_in = b; pending_in = 2'd3;
            end else begin
               error_in = utf8v_pkg::ERR_LEAD;
            end
         end else if (b[7:6] != 2'b10) begin
            error_in   = utf8v_pkg::ERR_CONT;
            pending_in = 2'd0;
         end else begin
            if (lead_ff[7:5] == 3'b110
                || (lead_ff[7:4] == 4'b1110 && pending_ff == 2'd2)
                || (lead_ff[7:3] == 5'b11110 && pending_ff == 2'd3))
               second_in = b;
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               if (strict_mode) e = utf8v_pkg::strict_check(lead_ff, second_in, b);
               if (e != utf8v_pkg::ERR_NONE) error_in = e;
               else accept = 1'b1;
            end
         end
      end

      if (accept) begin
         if (&count_ff) sat_in = 1'b1;
         else count_in = count_ff + utf8v_pkg::CountWidth'(1);
      end

      if (item.last && error_in == utf8v_pkg::ERR_NONE && pending_in != 2'd0)
         error_in = utf8v_pkg::ERR_TRUNC;

      result.valid_res        = (error_in == utf8v_pkg::ERR_NONE);
      result.error_kind       = error_in;
      result.code_point_count = 16'(count_in);
      result.count_saturated  = sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && item.last)) begin
         lead_ff    <= '0;
         second_ff  <= '0;
         pending_ff <= '0;
         error_ff   <= utf8v_pkg::ERR_NONE;
         count_ff   <= '0;
         sat_ff     <= 1'b0;
      end else if (advance) begin
         lead_ff    <= lead_in;
         second_ff  <= second_in;
         pending_ff <= pending_in;
         error_ff   <= error_in;
         count_ff   <= count_in;
         sat_ff     <= sat_in;
      end
   end

endmodule

// ----- hw/rtl/utf8v_rsp_reg.sv -----
`timescale 1ns / 1ps

// Result register with valid/ready towards the consumer.
module utf8v_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  utf8v_pkg::result_type load_data,
   output logic                  slot_free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output utf8v_pkg::result_type rsp_data
);

   logic                  valid_ff;
   utf8v_pkg::result_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

// ----- hw/rtl/utf8_strict_validate_count_unit.sv -----
`timescale 1ns / 1ps

// UTF-8 string checker and code point counter. Feed a string one byte per
// transaction on the req_ channel; req_last closes the string, and a
// transaction with req_has_byte low and req_last high closes it without a
// byte (an empty string if nothing came before). Exactly one rsp_
// transaction follows each closing transaction: rsp_valid_res, the first
// error seen (bad lead, bad continuation, truncated, and in strict mode
// overlong, surrogate, U+FFFE/U+FFFF or above U+10FFFF) and the number of
// code points accepted before the end or the first error, saturating, with
// rsp_count_saturated flagging the overflow. Bytes after the first error are
// ignored until the string closes. The block takes one byte every clock
// cycle: each transaction is held in the input register, where the decode
// state is updated, and a closing transaction then waits in the result
// register until the response is taken. The pace drops only while the
// result register is full and not taken.
// csr_strict_mode (reset 1) selects the value checks; write it only while
// the block is idle. No clearing pass is needed after reset.
module utf8_strict_validate_count_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valid_res,
   output logic [2:0]  rsp_error_kind,
   output logic [15:0] rsp_code_point_count,
   output logic        rsp_count_saturated,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_strict_mode
);

   logic                  strict_ff;
   logic                  in_valid_ff;
   utf8v_pkg::item_type   in_ff;
   logic                  advance;
   logic                  slot_free;
   utf8v_pkg::result_type core_result;
   utf8v_pkg::result_type rsp_data;

   // Configuration register: always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b1;
      end else if (csr_valid) begin
         strict_ff <= csr_strict_mode;
      end
   end

   // Advance the held transaction unless it closes a string and the
   // result register cannot take the response.
   assign advance   = in_valid_ff && (!in_ff.last || slot_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // Hold the payload until the next transaction is taken.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff.data_byte <= req_data_byte;
         in_ff.has_byte  <= req_has_byte;
         in_ff.last      <= req_last;
      end
   end

   utf8v_core u_core (
      .clock       (clock),
      .reset       (reset),
      .strict_mode (strict_ff),
      .advance     (advance),
      .item        (in_ff),
      .result      (core_result)
   );

   utf8v_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && in_ff.last),
      .load_data (core_result),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_valid_res        = rsp_data.valid_res;
   assign rsp_error_kind       = rsp_data.error_kind;
   assign rsp_code_point_count = rsp_data.code_point_count;
   assign rsp_count_saturated  = rsp_data.count_saturated;

endmodule
